FILE: rtl/bbne_pkg.sv
package bbne_pkg;

    localparam logic [6:0] START_OFFSET_RESET = 7'd5;
    localparam logic       REG_START_OFFSET   = 1'b0;

    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [6:0] VELOCITY_ON     = 7'd127;
    localparam logic [6:0] VELOCITY_OFF    = 7'd0;

    localparam logic [10:0] NOTE_BASE  = 11'd30;
    localparam logic [10:0] NOTE_LO    = 11'd60;
    localparam logic [10:0] NOTE_HI    = 11'd90;
    localparam logic [10:0] NOTE_SHIFT = 11'd31;
    localparam logic [10:0] NOTE_MAX   = 11'd127;

    // one classified report byte waiting for the back end
    typedef struct packed {
        logic [7:0] levels;
        logic [6:0] row;
        logic [7:0] mask;
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } t_state;

    function automatic logic [6:0] note_for(input logic [9:0] index);
        logic [10:0] note;
        note = {1'b0, index} + NOTE_BASE;
        if (note >= NOTE_LO && note <= NOTE_HI) begin
            note = note + NOTE_SHIFT;
        end
        if (note > NOTE_MAX) begin
            note = NOTE_MAX;
        end
        return note[6:0];
    endfunction

endpackage

FILE: rtl/bbne_front.sv
module bbne_front #(
    parameter int BUTTON_CAPACITY = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_report_byte,
    input  logic [6:0]        i_byte_offset,
    input  logic              i_q_full,
    output logic              o_q_push,
    output bbne_pkg::t_req    o_q_req
);

    localparam int         LEVEL_BYTES = (BUTTON_CAPACITY + 7) / 8;
    localparam int         LAST_BITS   = BUTTON_CAPACITY % 8;
    localparam logic [7:0] LAST_MASK   = (LAST_BITS == 0) ? 8'hFF : 8'((1 << LAST_BITS) - 1);
    localparam logic [6:0] LAST_ROW    = 7'(LEVEL_BYTES - 1);
    localparam logic [7:0] ROW_LIMIT   = 8'(LEVEL_BYTES);

    logic [6:0] r_start_offset;
    logic       cfg_wr;
    logic [7:0] diff;
    logic       in_range;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bbne_pkg::REG_START_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= bbne_pkg::START_OFFSET_RESET;
        end else if (cfg_wr) begin
            r_start_offset <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == bbne_pkg::REG_START_OFFSET) ? {25'd0, r_start_offset} : 32'd0;

    // bit 7 of the difference flags a byte ahead of the button area
    assign diff     = {1'b0, i_byte_offset} - {1'b0, r_start_offset};
    assign in_range = !diff[7] && ({1'b0, diff[6:0]} < ROW_LIMIT);

    assign o_in_stall     = i_q_full;
    assign o_q_push       = i_in_valid && !i_q_full && in_range;
    assign o_q_req.levels = i_report_byte;
    assign o_q_req.row    = diff[6:0];
    assign o_q_req.mask   = (diff[6:0] == LAST_ROW) ? LAST_MASK : 8'hFF;

endmodule

FILE: rtl/bbne_queue.sv
module bbne_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbne_pkg::t_req    i_req,
    input  logic              i_pop,
    output bbne_pkg::t_req    o_head,
    output logic              o_full,
    output logic              o_empty
);

    bbne_pkg::t_req r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/bbne_back.sv
module bbne_back #(
    parameter int BUTTON_CAPACITY = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbne_pkg::t_req    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_midi_status,
    output logic [6:0]        o_note_number,
    output logic [6:0]        o_velocity,
    output logic [8:0]        o_button_number,
    output logic              o_last_of_run
);

    localparam int LEVEL_BYTES = (BUTTON_CAPACITY + 7) / 8;
    localparam int ROW_W       = (LEVEL_BYTES > 1) ? $clog2(LEVEL_BYTES) : 1;

    bbne_pkg::t_state r_state, n_state;

    logic [7:0]       r_levels [LEVEL_BYTES];
    logic             r_row_valid [LEVEL_BYTES];
    logic [7:0]       r_rd_row;
    logic             r_rd_valid;
    bbne_pkg::t_req   r_req;
    logic [7:0]       r_pending, n_pending;

    logic             r_out_valid;
    logic [7:0]       r_midi_status;
    logic [6:0]       r_note_number;
    logic [6:0]       r_velocity;
    logic [8:0]       r_button_number;
    logic             r_last_of_run;

    logic [ROW_W-1:0] rd_addr;
    logic [ROW_W-1:0] wr_addr;
    logic [7:0]       prev_row;
    logic [7:0]       change;
    logic             wr_en;
    logic             out_free;
    logic             out_load;
    logic [2:0]       sel_bit;
    logic [7:0]       sel_onehot;
    logic [9:0]       index;
    logic             level;

    assign rd_addr  = i_head.row[ROW_W-1:0];
    assign wr_addr  = r_req.row[ROW_W-1:0];
    assign prev_row = r_rd_valid ? r_rd_row : 8'd0;
    assign change   = (r_req.levels ^ prev_row) & r_req.mask;
    assign out_free = !r_out_valid || !i_out_stall;

    // lowest pending bit goes first
    always_comb begin
        sel_bit = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (r_pending[b]) begin
                sel_bit = 3'(b);
            end
        end
    end

    assign sel_onehot = 8'd1 << sel_bit;
    assign index      = {r_req.row, sel_bit};
    assign level      = r_req.levels[sel_bit];

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            bbne_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = bbne_pkg::S_EVAL;
                end
            end
            bbne_pkg::S_EVAL: begin
                wr_en     = 1'b1;
                n_pending = change;
                n_state   = (change == 8'd0) ? bbne_pkg::S_IDLE : bbne_pkg::S_EMIT;
            end
            bbne_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    n_pending = r_pending & ~sel_onehot;
                    if (n_pending == 8'd0) begin
                        n_state = bbne_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bbne_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bbne_pkg::S_IDLE;
            r_pending <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

    // level store: registered read at pop, write-back in the evaluate cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_row <= r_levels[rd_addr];
        end
        if (wr_en) begin
            r_levels[wr_addr] <= prev_row ^ change;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVEL_BYTES; i++) begin
                r_row_valid[i] <= 1'b0;
            end
            r_rd_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rd_valid <= r_row_valid[rd_addr];
            end
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_midi_status   <= level ? bbne_pkg::STATUS_NOTE_ON : bbne_pkg::STATUS_NOTE_OFF;
            r_velocity      <= level ? bbne_pkg::VELOCITY_ON : bbne_pkg::VELOCITY_OFF;
            r_note_number   <= bbne_pkg::note_for(index);
            r_button_number <= index[8:0];
            r_last_of_run   <= (n_pending == 8'd0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_midi_status   = r_midi_status;
    assign o_note_number   = r_note_number;
    assign o_velocity      = r_velocity;
    assign o_button_number = r_button_number;
    assign o_last_of_run   = r_last_of_run;

endmodule

FILE: rtl/button_bitmap_to_note_events.sv
// A byte's first event passes the request queue, pop, evaluate state and output
// register. A byte holds the level-store loop for its pop, evaluate and one emit
// per event (0..8); events leave one per cycle while the output is not stalled.
// A two-entry request queue lets bytes be taken while earlier events drain.
// Reset (synchronous, active low) clears all button levels at once through
// per-row valid flags and sets start_offset to 5; no clearing pass is needed.
module button_bitmap_to_note_events #(
    parameter int BUTTON_CAPACITY = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_report_byte,
    input  logic [6:0]  i_byte_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_midi_status,
    output logic [6:0]  o_note_number,
    output logic [6:0]  o_velocity,
    output logic [8:0]  o_button_number,
    output logic        o_last_of_run
);

    bbne_pkg::t_req q_in_req;
    bbne_pkg::t_req q_head;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    bbne_front #(
        .BUTTON_CAPACITY(BUTTON_CAPACITY)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_report_byte (i_report_byte),
        .i_byte_offset (i_byte_offset),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_req       (q_in_req)
    );

    bbne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in_req),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bbne_back #(
        .BUTTON_CAPACITY(BUTTON_CAPACITY)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (q_head),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_midi_status   (o_midi_status),
        .o_note_number   (o_note_number),
        .o_velocity      (o_velocity),
        .o_button_number (o_button_number),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

FILE: rtl/bbne_checker.sv
module bbne_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_midi_status,
    input logic [6:0] o_note_number,
    input logic [6:0] o_velocity,
    input logic [8:0] o_button_number,
    input logic       o_last_of_run
);

    // a stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_midi_status)
            && $stable(o_note_number) && $stable(o_velocity)
            && $stable(o_button_number) && $stable(o_last_of_run))
        else $error("stalled note event changed");

    // status and velocity belong together
    a_status_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_midi_status == bbne_pkg::STATUS_NOTE_ON
                && o_velocity == bbne_pkg::VELOCITY_ON)
            || (o_midi_status == bbne_pkg::STATUS_NOTE_OFF
                && o_velocity == bbne_pkg::VELOCITY_OFF))
        else $error("status and velocity disagree");

    // the remap leaves a gap from 60 to 90
    a_note_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_note_number < 7'd60 || o_note_number > 7'd90)
        else $error("note inside remapped gap");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("event shown straight after reset");

endmodule

bind button_bitmap_to_note_events bbne_checker u_bbne_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_midi_status   (o_midi_status),
    .o_note_number   (o_note_number),
    .o_velocity      (o_velocity),
    .o_button_number (o_button_number),
    .o_last_of_run   (o_last_of_run)
);

FILE: dv/button_bitmap_to_note_events_test.sv
`timescale 1ns / 1ps

module button_bitmap_to_note_events_test;

    localparam int          CAPACITY     = 512;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          SETTLE       = 20;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [2:0]  START_ADDR   = {bbne_pkg::REG_START_OFFSET, 2'b00};

    typedef struct packed {
        logic [7:0] levels;
        logic [6:0] offset;
    } t_byte_req;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [8:0] button;
        logic       last;
    } t_note_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_report_byte = '0;
    logic [6:0]  i_byte_offset = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_midi_status;
    logic [6:0]  o_note_number;
    logic [6:0]  o_velocity;
    logic [8:0]  o_button_number;
    logic        o_last_of_run;

    t_byte_req     byte_reqs[$];
    t_note_event   note_events[$];
    t_byte_req     next_req;
    t_note_event   seen_event;
    t_note_event   due_event;
    logic [CAPACITY-1:0] held_levels = '0;
    logic [6:0]    start_now = bbne_pkg::START_OFFSET_RESET;
    int unsigned   send_gap = 0;
    int unsigned   stall_left = 0;
    int unsigned   calm_left = 0;
    logic          calm = 1'b0;
    logic          rx_hold = 1'b0;
    logic          hold_arm = 1'b0;
    int unsigned   cycles = 0;
    int unsigned   errors = 0;

    button_bitmap_to_note_events #(
        .BUTTON_CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_report_byte(i_report_byte),
        .i_byte_offset(i_byte_offset),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_midi_status(o_midi_status),
        .o_note_number(o_note_number),
        .o_velocity(o_velocity),
        .o_button_number(o_button_number),
        .o_last_of_run(o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [6:0] mapped_note(input int unsigned idx);
        int unsigned n;
        n = 30 + idx;
        if (n >= 60 && n <= 90) begin
            n = n + 31;
        end
        if (n > 127) begin
            n = 127;
        end
        return 7'(n);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 15);
        else return $urandom_range(30, 80);
    endfunction

    task automatic predict_events(input logic [7:0] levels, input logic [6:0] offset);
        int unsigned idx;
        int          made;
        t_note_event ev;
        made = 0;
        if (offset < start_now) return;
        for (int b = 0; b < 8; b++) begin
            idx = (int'(offset) - int'(start_now)) * 8 + b;
            if (idx >= CAPACITY) break;
            if (levels[b] != held_levels[idx]) begin
                held_levels[idx] = levels[b];
                ev.status   = levels[b] ? bbne_pkg::STATUS_NOTE_ON : bbne_pkg::STATUS_NOTE_OFF;
                ev.note     = mapped_note(idx);
                ev.velocity = levels[b] ? bbne_pkg::VELOCITY_ON : bbne_pkg::VELOCITY_OFF;
                ev.button   = 9'(idx);
                ev.last     = 1'b0;
                note_events.push_back(ev);
                made++;
            end
        end
        if (made > 0) begin
            ev = note_events.pop_back();
            ev.last = 1'b1;
            note_events.push_back(ev);
        end
    endtask

    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 2) == 0);
            calm_left <= $urandom_range(20, 300);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                predict_events(i_report_byte, i_byte_offset);
            end
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (byte_reqs.size() > 0) begin
                next_req      = byte_reqs.pop_front();
                i_report_byte <= next_req.levels;
                i_byte_offset <= next_req.offset;
                i_in_valid    <= 1'b1;
                send_gap      <= calm ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // event monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen_event = {o_midi_status, o_note_number, o_velocity,
                              o_button_number, o_last_of_run};
                if (note_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected st=%h note=%0d vel=%0d btn=%0d last=%b",
                             $time, o_midi_status, o_note_number, o_velocity,
                             o_button_number, o_last_of_run);
                end else begin
                    due_event = note_events.pop_front();
                    if (seen_event != due_event) begin
                        errors++;
                        $display("%0t: expected st=%h note=%0d vel=%0d btn=%0d last=%b",
                                 $time, due_event.status, due_event.note,
                                 due_event.velocity, due_event.button, due_event.last);
                        $display("%0t: actual   st=%h note=%0d vel=%0d btn=%0d last=%b",
                                 $time, o_midi_status, o_note_number, o_velocity,
                                 o_button_number, o_last_of_run);
                    end
                end
            end
            if (rx_hold) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall_left <= idle_len();
                end
            end
        end
    end

    // one long hold-off on the event side so the request queue backs up
    initial begin
        wait (hold_arm);
        repeat (10) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d events still expected", $time, note_events.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_req(input logic [7:0] levels, input logic [6:0] offset);
        t_byte_req r;
        r.levels = levels;
        r.offset = offset;
        byte_reqs.push_back(r);
    endtask

    // most bytes land on button rows of the current start; a tenth repeat the last one
    task automatic push_random(input int count);
        t_byte_req r;
        int unsigned off;
        r = '0;
        for (int k = 0; k < count; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0) begin
                byte_reqs.push_back(r);
            end else begin
                if ($urandom_range(0, 99) < 80) begin
                    off = start_now + $urandom_range(0, 63);
                    if (off > 127) off = 127;
                end else begin
                    off = $urandom_range(0, 127);
                end
                r.offset = 7'(off);
                r.levels = 8'($urandom_range(0, 255));
                byte_reqs.push_back(r);
            end
        end
    endtask

    task automatic drain();
        while (byte_reqs.size() > 0 || i_in_valid || note_events.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [6:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_ADDR;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        start_now = value;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // start offset still at its reset value
        push_req(8'hFF, 7'd0);
        push_req(8'hFF, 7'd4);
        push_req(8'hFF, 7'd5);
        push_req(8'hFF, 7'd5);
        push_req(8'h00, 7'd5);
        push_req(8'h55, 7'd5);
        push_req(8'hAA, 7'd5);
        push_req(8'hFF, 7'd8);
        push_req(8'h81, 7'd9);
        push_req(8'hFF, 7'd12);
        push_req(8'h00, 7'd12);
        push_req(8'hFF, 7'd17);
        push_req(8'hFF, 7'd68);
        push_req(8'h7F, 7'd68);
        push_req(8'hFF, 7'd69);
        push_req(8'hFF, 7'd127);
        push_req(8'h00, 7'd127);
        push_req(8'h01, 7'd6);
        push_req(8'h80, 7'd6);
        push_req(8'h00, 7'd0);
        drain();

        write_start(7'd0);
        push_random(200);
        hold_arm = 1'b1;
        drain();

        write_start(7'd127);
        push_req(8'hFF, 7'd126);
        push_random(40);
        drain();

        write_start(7'($urandom_range(1, 126)));
        push_random(100);
        drain();

        write_start(bbne_pkg::START_OFFSET_RESET);
        push_random(160);
        drain();

        if (errors == 0 && note_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
